### rtl/bam_pkg.sv
// ----------------------------------------------------------------------------
// bam_pkg: block average mosaic shared types and constants
// Pixel and result payloads, job record passed from front to back, widths.
// ----------------------------------------------------------------------------
package bam_pkg;

  localparam int MAX_REGION_WIDTH = 4096;
  localparam int MAX_BLOCK_SIZE   = 64;
  localparam int HEIGHT_LIMIT     = 4096;

  localparam int CHAN_W = 8;
  localparam int NCH    = 4;
  localparam int DIM_W  = 13;                                   // region width/height regs
  localparam int BS_W   = $clog2(MAX_BLOCK_SIZE + 1);           // block size reg
  localparam int OFF_W  = $clog2(MAX_BLOCK_SIZE);               // offset inside a block
  localparam int COL_W  = $clog2(MAX_REGION_WIDTH);             // x, block column
  localparam int ROW_W  = 12;                                   // y, block row
  localparam int CNT_W  = $clog2(MAX_BLOCK_SIZE * MAX_BLOCK_SIZE + 1);
  localparam int SUM_W  = CNT_W + CHAN_W - 1;                   // holds bs*bs*255
  localparam int STEP_W = $clog2(CHAN_W);
  localparam int JQ_DEPTH = 2;

  localparam int CFG_W   = 13;
  localparam int CFG_A_W = 2;
  localparam logic [CFG_A_W-1:0] REG_BLOCK_SIZE    = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_REGION_WIDTH  = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_REGION_HEIGHT = 2'd2;

  localparam logic [BS_W-1:0]  BS_RESET = BS_W'(8);
  localparam logic [DIM_W-1:0] W_RESET  = DIM_W'(1024);
  localparam logic [DIM_W-1:0] H_RESET  = DIM_W'(768);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [11:0]       block_col;
    logic [11:0]       block_row;
    logic [CHAN_W-1:0] avg_red;
    logic [CHAN_W-1:0] avg_green;
    logic [CHAN_W-1:0] avg_blue;
    logic [CHAN_W-1:0] avg_alpha;
    logic              final_block;
  } result_t;

  typedef logic [NCH-1:0][SUM_W-1:0] sums_t;   // index 0 red .. 3 alpha

  // effective (clamped) geometry
  typedef struct packed {
    logic [BS_W-1:0]  bs;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } geom_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    sums_t            sums;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } job_t;

endpackage

### rtl/bam_ram.sv
// ----------------------------------------------------------------------------
// bam_ram: generic simple dual port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bam_front.sv
// ----------------------------------------------------------------------------
// bam_front: pixel intake and column accumulation
// Tracks raster position, read-modify-writes the per block column sums and
// hands a job to the queue when a pixel closes a block.
// ----------------------------------------------------------------------------
module bam_front import bam_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   restart,
  input  geom_t  geom,
  input  logic   push,
  input  pixel_t pixel,
  output logic   full,
  input  logic   jq_ready,
  output logic   job_push,
  output job_t   job
);

  logic [COL_W-1:0] x, bc, wr_col, clr_addr;
  logic [ROW_W-1:0] y, br, row_q;
  logic [OFF_W-1:0] xo, yo;
  logic             clearing, busy, emit_q, last_q;
  logic [CNT_W-1:0] cnt_q;
  pixel_t           pix_q;

  logic             accept, end_x, end_y, x_wrap, y_wrap;
  logic [BS_W-1:0]  xo_inc, yo_inc;
  logic [DIM_W-1:0] x_inc, y_inc;
  logic [2*BS_W-1:0] area;
  logic [NCH-1:0][CHAN_W-1:0] pix_ch;
  sums_t            rd_sums, new_sums, wr_sums;
  logic             we;
  logic [COL_W-1:0] waddr;

  assign accept = push && !full;
  assign full   = clearing || busy || !jq_ready;

  assign xo_inc = BS_W'(xo) + BS_W'(1);
  assign yo_inc = BS_W'(yo) + BS_W'(1);
  assign x_inc  = DIM_W'(x) + DIM_W'(1);
  assign y_inc  = DIM_W'(y) + DIM_W'(1);
  assign x_wrap = (x_inc == geom.w);
  assign y_wrap = (y_inc == geom.h);
  assign end_x  = (xo_inc == geom.bs) || x_wrap;
  assign end_y  = (yo_inc == geom.bs) || y_wrap;
  assign area   = (2*BS_W)'(xo_inc) * (2*BS_W)'(yo_inc);

  assign pix_ch = {pix_q.alpha, pix_q.blue, pix_q.green, pix_q.red};

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      new_sums[c] = rd_sums[c] + SUM_W'(pix_ch[c]);
    end
  end

  always_comb begin
    we      = clearing || busy;
    waddr   = clearing ? clr_addr : wr_col;
    wr_sums = (clearing || emit_q) ? '0 : new_sums;
  end

  bam_ram #(.WIDTH(NCH*SUM_W), .DEPTH(MAX_REGION_WIDTH)) u_sums (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_sums),
    .raddr (bc),
    .rdata (rd_sums)
  );

  assign job_push = busy && emit_q;
  assign job.col  = wr_col;
  assign job.row  = row_q;
  assign job.sums = new_sums;
  assign job.cnt  = cnt_q;
  assign job.last = last_q;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      busy     <= 1'b0;
      x <= '0; y <= '0; xo <= '0; yo <= '0; bc <= '0; br <= '0;
    end else begin
      if (clearing && clr_addr == COL_W'(MAX_REGION_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + COL_W'(1);
      busy     <= accept;
      if (accept) begin
        pix_q  <= pixel;
        emit_q <= end_x && end_y;
        last_q <= x_wrap && y_wrap;
        cnt_q  <= area[CNT_W-1:0];
        wr_col <= bc;
        row_q  <= br;
        if (x_wrap) begin
          x <= '0; xo <= '0; bc <= '0;
          if (y_wrap) begin
            y <= '0; yo <= '0; br <= '0;
          end else begin
            y <= y + ROW_W'(1);
            if (yo_inc == geom.bs) begin
              yo <= '0;
              br <= br + ROW_W'(1);
            end else begin
              yo <= yo + OFF_W'(1);
            end
          end
        end else begin
          x <= x + COL_W'(1);
          if (xo_inc == geom.bs) begin
            xo <= '0;
            bc <= bc + COL_W'(1);
          end else begin
            xo <= xo + OFF_W'(1);
          end
        end
      end
    end
  end

endmodule

### rtl/bam_jobq.sv
// ----------------------------------------------------------------------------
// bam_jobq: short job queue between front and back
// Holds finished block sums until the divider takes them.
// ----------------------------------------------------------------------------
module bam_jobq import bam_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic ready,
  output logic valid,
  input  logic pop,
  output job_t dout
);

  localparam int PTR_W = $clog2(JQ_DEPTH);
  localparam int CNT_QW = $clog2(JQ_DEPTH + 1);

  job_t              slots [JQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_QW-1:0] count;

  assign ready = (count != CNT_QW'(JQ_DEPTH));
  assign valid = (count != '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(JQ_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(JQ_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_QW'(push) - CNT_QW'(pop);
    end
  end

endmodule

### rtl/bam_back.sv
// ----------------------------------------------------------------------------
// bam_back: block averaging
// Restoring divider, one quotient bit per cycle on all four channels at
// once, then an output register presented as the result queue head.
// ----------------------------------------------------------------------------
module bam_back import bam_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  input  job_t    job,
  output logic    job_pop,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic                       div_busy, done, out_valid;
  logic [STEP_W-1:0]          step;
  logic [NCH-1:0][SUM_W-1:0]  rem;
  logic [NCH-1:0][CHAN_W-1:0] quo;
  logic [SUM_W-1:0]           dvs;
  logic [COL_W-1:0]           col_q;
  logic [ROW_W-1:0]           row_q;
  logic                       last_q, load_out;

  assign empty    = !out_valid;
  assign job_pop  = job_valid && !div_busy && !done;
  assign load_out = done && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy  <= 1'b0;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_pop) begin
        rem      <= job.sums;
        quo      <= '0;
        dvs      <= SUM_W'(job.cnt) << (CHAN_W - 1);
        step     <= '0;
        col_q    <= job.col;
        row_q    <= job.row;
        last_q   <= job.last;
        div_busy <= 1'b1;
      end else if (div_busy) begin
        for (int c = 0; c < NCH; c++) begin
          if (rem[c] >= dvs) begin
            rem[c] <= rem[c] - dvs;
            quo[c] <= {quo[c][CHAN_W-2:0], 1'b1};
          end else begin
            quo[c] <= {quo[c][CHAN_W-2:0], 1'b0};
          end
        end
        dvs  <= dvs >> 1;
        step <= step + STEP_W'(1);
        if (step == STEP_W'(CHAN_W - 1)) begin
          div_busy <= 1'b0;
          done     <= 1'b1;
        end
      end
      if (load_out) begin
        done                <= 1'b0;
        out_valid           <= 1'b1;
        result.block_col    <= col_q;
        result.block_row    <= row_q;
        result.avg_red      <= quo[0];
        result.avg_green    <= quo[1];
        result.avg_blue     <= quo[2];
        result.avg_alpha    <= quo[3];
        result.final_block  <= last_q;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/block_average_mosaic.sv
// ----------------------------------------------------------------------------
// block_average_mosaic: block average pixelation over a clipped region
//
//   channel | direction | handshake        | payload
//   pixel   | in        | push / full      | pixel_t  (red, green, blue, alpha)
//   result  | out       | empty / pop      | result_t (block pos, averages, final)
//   config  | in        | cfg_we, cfg_addr | cfg_wdata
//
// A pixel is a read-modify-write of its column sum in the sums RAM (registered
// read, then write-back). A closed block is divided in the back end,
// overlapped with intake through a 2-entry job queue; full also rises while
// that queue is full. Reset and every config write start a clearing pass over
// the sums RAM, with full held high.
// ----------------------------------------------------------------------------
module block_average_mosaic import bam_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  pixel_t             pixel,
  output logic               empty,
  input  logic               pop,
  output result_t            result,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  logic [BS_W-1:0]  block_size;
  logic [DIM_W-1:0] region_width, region_height;
  geom_t            geom;
  logic             jq_ready, jq_push, jq_valid, jq_pop;
  job_t             jq_in, jq_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size    <= BS_RESET;
      region_width  <= W_RESET;
      region_height <= H_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BLOCK_SIZE:    block_size    <= cfg_wdata[BS_W-1:0];
        REG_REGION_WIDTH:  region_width  <= cfg_wdata[DIM_W-1:0];
        REG_REGION_HEIGHT: region_height <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // zero means one, oversize saturates
  always_comb begin
    geom.bs = block_size;
    if (block_size == '0) geom.bs = BS_W'(1);
    else if (block_size > BS_W'(MAX_BLOCK_SIZE)) geom.bs = BS_W'(MAX_BLOCK_SIZE);
    geom.w = region_width;
    if (region_width == '0) geom.w = DIM_W'(1);
    else if (region_width > DIM_W'(MAX_REGION_WIDTH)) geom.w = DIM_W'(MAX_REGION_WIDTH);
    geom.h = region_height;
    if (region_height == '0) geom.h = DIM_W'(1);
    else if (region_height > DIM_W'(HEIGHT_LIMIT)) geom.h = DIM_W'(HEIGHT_LIMIT);
  end

  bam_front u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (cfg_we),
    .geom     (geom),
    .push     (push),
    .pixel    (pixel),
    .full     (full),
    .jq_ready (jq_ready),
    .job_push (jq_push),
    .job      (jq_in)
  );

  bam_jobq u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (jq_push),
    .din   (jq_in),
    .ready (jq_ready),
    .valid (jq_valid),
    .pop   (jq_pop),
    .dout  (jq_out)
  );

  bam_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (jq_valid),
    .job       (jq_out),
    .job_pop   (jq_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

### rtl/bam_checker.sv
// ----------------------------------------------------------------------------
// bam_checker: port level checks for block_average_mosaic
// Reset and restart behavior, intake spacing, result hold under stall.
// ----------------------------------------------------------------------------
module bam_checker import bam_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    push,
  input logic    full,
  input logic    empty,
  input logic    pop,
  input result_t result,
  input logic    cfg_we
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst) cfg_we |=> full)
    else $error("no clearing pass after config write");

  a_pixel_gap: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !cfg_we) |=> full)
    else $error("pixel taken during column update");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result changed");

endmodule

bind block_average_mosaic bam_checker u_bam_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result),
  .cfg_we (cfg_we)
);

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: block average mosaic testbench
// Streams RGBA pixels over several region geometries, predicts each finished
// block's position and channel means, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import bam_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // register index with no register behind it
  localparam logic [CFG_A_W-1:0] REG_SPARE = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  pixel_t             pixel = '0;
  logic               empty;
  logic               pop = 1'b0;
  result_t            result;
  logic               cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  block_average_mosaic dut (.*);

  always #4 clk = ~clk;

  // configuration copy and mosaic state
  int unsigned cur_bs, cur_w, cur_h;
  int unsigned px, py;
  int unsigned acc [MAX_REGION_WIDTH][NCH];
  result_t     pending_blocks [$];

  int  errors = 0;
  int  n_pixels = 0;
  int  n_blocks = 0;
  int  n_cfg = 0;
  longint cycles = 0;
  bit  rx_hold = 1'b0;

  function automatic void clear_region();
    foreach (acc[i, c]) acc[i][c] = 0;
    px = 0;
    py = 0;
  endfunction

  function automatic void mosaic_step(pixel_t p);
    int unsigned bs, w, h, bc, br, cnt;
    bit ex, ey;
    result_t r;
    bs = (cur_bs == 0) ? 1 : (cur_bs > MAX_BLOCK_SIZE ? MAX_BLOCK_SIZE : cur_bs);
    w  = (cur_w == 0) ? 1 : (cur_w > MAX_REGION_WIDTH ? MAX_REGION_WIDTH : cur_w);
    h  = (cur_h == 0) ? 1 : (cur_h > HEIGHT_LIMIT ? HEIGHT_LIMIT : cur_h);
    if (px >= w) px = 0;
    if (py >= h) py = 0;
    bc = px / bs;
    br = py / bs;
    acc[bc][0] += p.red;
    acc[bc][1] += p.green;
    acc[bc][2] += p.blue;
    acc[bc][3] += p.alpha;
    ex = ((px + 1) % bs == 0) || (px + 1 == w);
    ey = ((py + 1) % bs == 0) || (py + 1 == h);
    if (ex && ey) begin
      cnt = (px + 1 - bc * bs) * (py + 1 - br * bs);
      if (cnt == 0) cnt = 1;
      r.block_col   = 12'(bc);
      r.block_row   = 12'(br);
      r.avg_red     = 8'(acc[bc][0] / cnt);
      r.avg_green   = 8'(acc[bc][1] / cnt);
      r.avg_blue    = 8'(acc[bc][2] / cnt);
      r.avg_alpha   = 8'(acc[bc][3] / cnt);
      r.final_block = (px + 1 == w) && (py + 1 == h);
      pending_blocks.push_back(r);
      for (int c = 0; c < NCH; c++) acc[bc][c] = 0;
    end
    if (px + 1 >= w) begin
      px = 0;
      py = (py + 1 >= h) ? 0 : py + 1;
    end else begin
      px = px + 1;
    end
  endfunction

  // push stays up after the accepting edge; drain, or a next call with a gap, drops it
  task automatic send_pixel(pixel_t p, bit gaps = 1'b1);
    int gap;
    gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5)) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push  <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (full);
    mosaic_step(p);
    n_pixels++;
  endtask

  function automatic pixel_t rand_pixel();
    return pixel_t'($urandom);
  endfunction

  // waits for all results, then lets the divider drain before a write
  task automatic drain();
    push <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_A_W-1:0] idx, int unsigned val);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BLOCK_SIZE:    cur_bs = val & 32'h7f;
      REG_REGION_WIDTH:  cur_w  = val & 32'h1fff;
      REG_REGION_HEIGHT: cur_h  = val & 32'h1fff;
      default: ;
    endcase
    clear_region();
    n_cfg++;
  endtask

  task automatic set_geometry(int unsigned bs, int unsigned w, int unsigned h);
    write_reg(REG_BLOCK_SIZE, bs);
    write_reg(REG_REGION_WIDTH, w);
    write_reg(REG_REGION_HEIGHT, h);
  endtask

  task automatic test_extremes();
    pixel_t p;
    set_geometry(2, 3, 3);
    send_pixel('0);
    send_pixel('1);
    send_pixel(pixel_t'(32'hff00ff00));
    send_pixel(pixel_t'(32'h00ff00ff));
    for (int i = 0; i < 5; i++) send_pixel(rand_pixel());
    // region wraps: next pixel starts a new region
    for (int i = 0; i < 9; i++) send_pixel('1);
    // zero sizes read as 1, oversize values saturate
    set_geometry(0, 0, 0);
    send_pixel(rand_pixel());
    send_pixel(rand_pixel());
    set_geometry(127, 8191, 1);
    for (int i = 0; i < 4; i++) send_pixel(rand_pixel());
    // write to the unused index restarts the region
    write_reg(REG_SPARE, $urandom);
    p = rand_pixel();
    send_pixel(p);
  endtask

  task automatic test_random_regions();
    int unsigned bs, w, h, n;
    for (int k = 0; k < 6; k++) begin
      bs = (k == 0) ? 64 : (k == 1) ? 1 : $urandom_range(1, 9);
      w  = (k == 0) ? 70 : $urandom_range(1, 24);
      h  = (k == 0) ? 65 : $urandom_range(1, 12);
      set_geometry(bs, w, h);
      n = (k == 0) ? 0 : w * h + $urandom_range(0, w);
      if (k == 0) n = 70 * 2;   // most of a huge block stays open: short
      for (int i = 0; i < n; i++) send_pixel(rand_pixel());
    end
  endtask

  task automatic test_backpressure();
    set_geometry(1, 16, 16);
    fork
      begin
        rx_hold = 1'b1;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 200; i++) send_pixel(rand_pixel(), 1'b0);
    join
    drain();
    for (int i = 0; i < 56; i++) send_pixel(rand_pixel());
  endtask

  task automatic test_reset_geometry();
    // reset block size and height, narrow region, one full block row
    set_geometry(8, 96, 768);
    for (int i = 0; i < 96 * 8; i += 1) send_pixel(rand_pixel(), 1'b0);
  endtask

  // result side: random pop gaps, compare in order
  initial begin
    result_t exp_r;
    int      gap;
    forever begin
      gap = $urandom_range(0, 5);
      if (gap != 0 || rx_hold) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (pending_blocks.size() == 0) begin
        $error("result with nothing expected: %p", result);
        errors++;
      end else begin
        exp_r = pending_blocks.pop_front();
        n_blocks++;
        if (result.block_col !== exp_r.block_col) begin
          $error("block_col exp %0d got %0d", exp_r.block_col, result.block_col); errors++;
        end
        if (result.block_row !== exp_r.block_row) begin
          $error("block_row exp %0d got %0d", exp_r.block_row, result.block_row); errors++;
        end
        if (result.avg_red !== exp_r.avg_red) begin
          $error("avg_red exp %0d got %0d", exp_r.avg_red, result.avg_red); errors++;
        end
        if (result.avg_green !== exp_r.avg_green) begin
          $error("avg_green exp %0d got %0d", exp_r.avg_green, result.avg_green); errors++;
        end
        if (result.avg_blue !== exp_r.avg_blue) begin
          $error("avg_blue exp %0d got %0d", exp_r.avg_blue, result.avg_blue); errors++;
        end
        if (result.avg_alpha !== exp_r.avg_alpha) begin
          $error("avg_alpha exp %0d got %0d", exp_r.avg_alpha, result.avg_alpha); errors++;
        end
        if (result.final_block !== exp_r.final_block) begin
          $error("final_block exp %0d got %0d", exp_r.final_block, result.final_block);
          errors++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    cur_bs = 8;
    cur_w  = 1024;
    cur_h  = 768;
    clear_region();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_random_regions();
    test_backpressure();
    test_reset_geometry();
    drain();
    $display("pixels %0d, blocks checked %0d, register writes %0d", n_pixels, n_blocks,
             n_cfg);
    if (errors == 0 && pending_blocks.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
